// File: rtl/phwc_pkg.sv
//==============================================================================
// phwc_pkg: shared constants for the pulse height window classifier
// Field widths, register reset values, register codes and word layouts.
//==============================================================================
`default_nettype none

package phwc_pkg;

    // Field widths
    localparam int SAMPLE_W  = 11;
    localparam int INDEX_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int OFFSET_W  = 16;
    localparam int KEV_W     = 20;
    localparam int HEIGHT_W  = 12;
    localparam int ENERGY_W  = 21;
    localparam int TOTAL_W   = 32;

    // Baseline window defaults
    localparam int BASELINE_START_DEF = 400;
    localparam int BASELINE_LEN_DEF   = 50;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN               = 3'd0,
        CFG_OFFSET             = 3'd1,
        CFG_THRESHOLD          = 3'd2,
        CFG_FIRST_WINDOW_LOW   = 3'd3,
        CFG_FIRST_WINDOW_HIGH  = 3'd4,
        CFG_SECOND_WINDOW_LOW  = 3'd5,
        CFG_SECOND_WINDOW_HIGH = 3'd6,
        CFG_VETO_LEVEL         = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]          GAIN_RST      = 16'd1229;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST    = 16'sd0;
    localparam logic [KEV_W-1:0]           THRESHOLD_RST = 20'd2000;
    localparam logic [KEV_W-1:0]           FW_LOW_RST    = 20'd5469;
    localparam logic [KEV_W-1:0]           FW_HIGH_RST   = 20'd6002;
    localparam logic [KEV_W-1:0]           SW_LOW_RST    = 20'd7004;
    localparam logic [KEV_W-1:0]           SW_HIGH_RST   = 20'd7686;
    localparam logic signed [SAMPLE_W-1:0] VETO_RST      = -11'sd1024;
    localparam logic signed [SAMPLE_W-1:0] PEAK_RST      = -11'sd1024;

    // Stream word widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 104;

    // Result word layout (lowest bit of each field)
    localparam int OUT_HEIGHT_LSB = 0;
    localparam int OUT_ENERGY_LSB = 12;
    localparam int OUT_VETOED_BIT = 33;
    localparam int OUT_ABOVE_BIT  = 34;
    localparam int OUT_HIT1_BIT   = 35;
    localparam int OUT_HIT2_BIT   = 36;
    localparam int OUT_TOT1_LSB   = 37;
    localparam int OUT_TOT2_LSB   = 69;
    localparam int OUT_PAD_LSB    = 101;

endpackage

`default_nettype wire

// File: rtl/pulse_height_window_classifier.sv
//==============================================================================
// pulse_height_window_classifier: baseline-subtracted pulse height analyzer
// Tracks baseline, peak and veto per event and classifies the calibrated energy.
//==============================================================================
// The block takes one word per clock cycle on the input stream, sustained
// while the output side does not stall: a waveform sample (tuser low) or an
// end-of-event marker (tuser high). Sample words only update the event state
// (sample index, baseline sum over the baseline window, running peak, veto
// flag) and never produce a result. Each marker after the first one produces
// one result word. The word passes five registers: the event snapshot, loaded
// at the accepting edge, then the baseline division (a multiply by the
// reciprocal of BASELINE_LEN), the height, the gain multiply, and the output
// register that takes offset, saturation, window compares and the running hit
// totals. The first marker after reset only clears the event. Every stage
// holds its word when the next one is full, so a stalled output does not
// block input until the pipeline has filled. Configuration writes are taken
// at any edge where cfg_we is high and must only be issued while no result is
// outstanding.
//==============================================================================
`default_nettype none

module pulse_height_window_classifier #(
    parameter int BASELINE_START = phwc_pkg::BASELINE_START_DEF,
    parameter int BASELINE_LEN   = phwc_pkg::BASELINE_LEN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [phwc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [phwc_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [phwc_pkg::IN_DATA_W-1:0]      s_tdata,   // [10:0] sample, [15:11] zero
    input  wire logic                                s_tuser,   // [0] action (1 = marker)

    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [phwc_pkg::OUT_DATA_W-1:0]          m_tdata    // [11:0] pulse_height,
                                                                // [32:12] energy_kev,
                                                                // [33] vetoed,
                                                                // [34] above_threshold,
                                                                // [35] first_window_hit,
                                                                // [36] second_window_hit,
                                                                // [68:37] first_window_total,
                                                                // [100:69] second_window_total,
                                                                // [103:101] zero
);

    // Baseline sum width: at most BASELINE_LEN-1 samples of magnitude 1024
    // land in the window, so the magnitude fits ABS_W bits.
    localparam int ABS_W    = $clog2((BASELINE_LEN - 1) * 1024 + 1);
    localparam int SUM_W    = ABS_W + 1;
    // Exact floor division by BASELINE_LEN: for x < 2**ABS_W,
    // floor(x / LEN) == (x * ceil(2**SH / LEN)) >> SH with SH below.
    localparam int SH       = ABS_W + $clog2(BASELINE_LEN);
    localparam int RECIP_W  = ABS_W + 2;
    localparam int PROD_W   = ABS_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SH) + 64'(BASELINE_LEN) - 64'd1) / 64'(BASELINE_LEN));
    localparam int WIN_W    = phwc_pkg::INDEX_W + 1;
    localparam logic [WIN_W-1:0] WIN_LO = WIN_W'(BASELINE_START);
    localparam logic [WIN_W-1:0] WIN_HI = WIN_W'(BASELINE_START + BASELINE_LEN);
    localparam int MUL_W    = phwc_pkg::GAIN_W + 1 + phwc_pkg::HEIGHT_W;
    localparam int E_W      = phwc_pkg::ENERGY_W + 1;

    //--------------------------------------------------------------------------
    // Configuration registers
    //--------------------------------------------------------------------------
    logic [phwc_pkg::GAIN_W-1:0]          gain_reg;
    logic signed [phwc_pkg::OFFSET_W-1:0] offset_reg;
    logic [phwc_pkg::KEV_W-1:0]           threshold_reg;
    logic [phwc_pkg::KEV_W-1:0]           fw_low_reg;
    logic [phwc_pkg::KEV_W-1:0]           fw_high_reg;
    logic [phwc_pkg::KEV_W-1:0]           sw_low_reg;
    logic [phwc_pkg::KEV_W-1:0]           sw_high_reg;
    logic signed [phwc_pkg::SAMPLE_W-1:0] veto_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= phwc_pkg::GAIN_RST;
            offset_reg     <= phwc_pkg::OFFSET_RST;
            threshold_reg  <= phwc_pkg::THRESHOLD_RST;
            fw_low_reg     <= phwc_pkg::FW_LOW_RST;
            fw_high_reg    <= phwc_pkg::FW_HIGH_RST;
            sw_low_reg     <= phwc_pkg::SW_LOW_RST;
            sw_high_reg    <= phwc_pkg::SW_HIGH_RST;
            veto_level_reg <= phwc_pkg::VETO_RST;
        end
        else if (cfg_we)
        begin
            case (phwc_pkg::cfg_reg_t'(cfg_index))
                phwc_pkg::CFG_GAIN:               gain_reg       <= cfg_data[15:0];
                phwc_pkg::CFG_OFFSET:             offset_reg     <= $signed(cfg_data[15:0]);
                phwc_pkg::CFG_THRESHOLD:          threshold_reg  <= cfg_data;
                phwc_pkg::CFG_FIRST_WINDOW_LOW:   fw_low_reg     <= cfg_data;
                phwc_pkg::CFG_FIRST_WINDOW_HIGH:  fw_high_reg    <= cfg_data;
                phwc_pkg::CFG_SECOND_WINDOW_LOW:  sw_low_reg     <= cfg_data;
                phwc_pkg::CFG_SECOND_WINDOW_HIGH: sw_high_reg    <= cfg_data;
                phwc_pkg::CFG_VETO_LEVEL:         veto_level_reg <= $signed(cfg_data[10:0]);
                default:                          ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its word moves on.
    //--------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;

    assign ld_out   = !out_valid_reg || m_tready;
    assign ld4      = !v4_reg || ld_out;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    //--------------------------------------------------------------------------
    // Event state, updated at every accepted word
    //--------------------------------------------------------------------------
    logic [phwc_pkg::INDEX_W-1:0]         index_reg;
    logic signed [SUM_W-1:0]              sum_reg;
    logic signed [phwc_pkg::SAMPLE_W-1:0] peak_reg;
    logic                                 veto_reg;
    logic                                 seen_reg;

    logic                                 accept;
    logic                                 is_marker;
    logic                                 report;
    logic signed [phwc_pkg::SAMPLE_W-1:0] smp;
    logic                                 in_window;

    assign accept    = s_tvalid && ld1;
    assign is_marker = s_tuser;
    assign report    = accept && is_marker && seen_reg;
    assign smp       = $signed(s_tdata[phwc_pkg::SAMPLE_W-1:0]);
    assign in_window = ({1'b0, index_reg} > WIN_LO) && ({1'b0, index_reg} < WIN_HI);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            sum_reg   <= '0;
            peak_reg  <= phwc_pkg::PEAK_RST;
            veto_reg  <= 1'b0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (is_marker)
            begin
                // Every marker closes the event; only the first one is silent.
                seen_reg  <= 1'b1;
                index_reg <= '0;
                sum_reg   <= '0;
                peak_reg  <= phwc_pkg::PEAK_RST;
                veto_reg  <= 1'b0;
            end
            else
            begin
                if (in_window)
                begin
                    sum_reg <= sum_reg + {{(SUM_W-phwc_pkg::SAMPLE_W){smp[phwc_pkg::SAMPLE_W-1]}},
                                          smp};
                end
                if (smp > peak_reg)
                begin
                    peak_reg <= smp;
                end
                if (smp < veto_level_reg)
                begin
                    veto_reg <= 1'b1;
                end
                if (index_reg != {phwc_pkg::INDEX_W{1'b1}})
                begin
                    index_reg <= index_reg + 1'b1;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stage 1: event snapshot; stage 2 input is |sum| times the reciprocal.
    //--------------------------------------------------------------------------
    logic signed [SUM_W-1:0]              sum1_reg;
    logic signed [phwc_pkg::SAMPLE_W-1:0] peak1_reg;
    logic                                 veto1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ld1)
        begin
            v1_reg <= report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && report)
        begin
            sum1_reg  <= sum_reg;
            peak1_reg <= peak_reg;
            veto1_reg <= veto_reg;
        end
    end

    logic [SUM_W-1:0]  abs1_full;
    logic [ABS_W-1:0]  abs1;
    logic [PROD_W-1:0] div_prod;

    assign abs1_full = sum1_reg[SUM_W-1] ? (~sum1_reg + 1'b1) : sum1_reg;
    assign abs1      = abs1_full[ABS_W-1:0];
    assign div_prod  = {{RECIP_W{1'b0}}, abs1} * {{ABS_W{1'b0}}, RECIP};

    //--------------------------------------------------------------------------
    // Stage 2: baseline magnitude and sign
    //--------------------------------------------------------------------------
    logic [QUOT_W-1:0]                    quot2_reg;
    logic                                 neg2_reg;
    logic signed [phwc_pkg::SAMPLE_W-1:0] peak2_reg;
    logic                                 veto2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ld2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            quot2_reg <= div_prod[PROD_W-1:SH];
            neg2_reg  <= sum1_reg[SUM_W-1];
            peak2_reg <= peak1_reg;
            veto2_reg <= veto1_reg;
        end
    end

    // Baseline truncates toward zero, so the sign goes back on the magnitude.
    logic [phwc_pkg::SAMPLE_W:0]          base_mag;
    logic signed [phwc_pkg::SAMPLE_W+1:0] baseline;
    logic signed [phwc_pkg::SAMPLE_W+1:0] height_raw;
    logic signed [phwc_pkg::HEIGHT_W-1:0] height_next;

    assign base_mag   = (phwc_pkg::SAMPLE_W+1)'(quot2_reg);
    assign baseline   = neg2_reg ? -$signed({1'b0, base_mag}) : $signed({1'b0, base_mag});
    assign height_raw = {{2{peak2_reg[phwc_pkg::SAMPLE_W-1]}}, peak2_reg} - baseline;

    always_comb
    begin
        if (height_raw > 13'sd2047)
        begin
            height_next = 12'sd2047;
        end
        else if (height_raw < -13'sd2047)
        begin
            height_next = -12'sd2047;
        end
        else
        begin
            height_next = height_raw[phwc_pkg::HEIGHT_W-1:0];
        end
    end

    //--------------------------------------------------------------------------
    // Stage 3: pulse height
    //--------------------------------------------------------------------------
    logic signed [phwc_pkg::HEIGHT_W-1:0] height3_reg;
    logic                                 veto3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ld3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            height3_reg <= height_next;
            veto3_reg   <= veto2_reg;
        end
    end

    logic signed [MUL_W-1:0] gain_prod;

    assign gain_prod = $signed({1'b0, gain_reg}) * height3_reg;

    //--------------------------------------------------------------------------
    // Stage 4: scaled product
    //--------------------------------------------------------------------------
    logic signed [MUL_W-1:0]              prod4_reg;
    logic signed [phwc_pkg::HEIGHT_W-1:0] height4_reg;
    logic                                 veto4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ld4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            prod4_reg   <= gain_prod;
            height4_reg <= height3_reg;
            veto4_reg   <= veto3_reg;
        end
    end

    // Arithmetic shift rounds toward minus infinity, then offset and clamp.
    logic signed [MUL_W-9:0]                scaled;
    logic signed [E_W-1:0]                  energy_wide;
    logic signed [phwc_pkg::ENERGY_W-1:0]   energy_next;
    logic signed [E_W-1:0]                  energy_cmp;
    logic                                   ok;
    logic                                   above_next;
    logic                                   hit1_next;
    logic                                   hit2_next;

    assign scaled      = prod4_reg[MUL_W-1:8];
    assign energy_wide = E_W'(scaled)
                       + {{(E_W-phwc_pkg::OFFSET_W){offset_reg[phwc_pkg::OFFSET_W-1]}},
                          offset_reg};

    always_comb
    begin
        if (energy_wide > $signed(22'sd1048575))
        begin
            energy_next = 21'sd1048575;
        end
        else if (energy_wide < -$signed(22'sd1048576))
        begin
            energy_next = -21'sd1048576;
        end
        else
        begin
            energy_next = energy_wide[phwc_pkg::ENERGY_W-1:0];
        end
    end

    assign energy_cmp = {energy_next[phwc_pkg::ENERGY_W-1], energy_next};
    assign ok         = !veto4_reg;
    assign above_next = ok && (energy_cmp > $signed({2'b00, threshold_reg}));
    assign hit1_next  = ok && (energy_cmp > $signed({2'b00, fw_low_reg}))
                           && (energy_cmp < $signed({2'b00, fw_high_reg}));
    assign hit2_next  = ok && (energy_cmp > $signed({2'b00, sw_low_reg}))
                           && (energy_cmp < $signed({2'b00, sw_high_reg}));

    //--------------------------------------------------------------------------
    // Output stage: result word and saturating hit totals
    //--------------------------------------------------------------------------
    logic [phwc_pkg::TOTAL_W-1:0] total1_reg;
    logic [phwc_pkg::TOTAL_W-1:0] total2_reg;
    logic [phwc_pkg::TOTAL_W-1:0] total1_next;
    logic [phwc_pkg::TOTAL_W-1:0] total2_next;
    logic [phwc_pkg::OUT_DATA_W-1:0] data_reg;

    assign total1_next = (hit1_next && (total1_reg != {phwc_pkg::TOTAL_W{1'b1}}))
                       ? total1_reg + 1'b1 : total1_reg;
    assign total2_next = (hit2_next && (total2_reg != {phwc_pkg::TOTAL_W{1'b1}}))
                       ? total2_reg + 1'b1 : total2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total1_reg    <= '0;
            total2_reg    <= '0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                total1_reg <= total1_next;
                total2_reg <= total2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && v4_reg)
        begin
            data_reg <= {3'b000, total2_next, total1_next, hit2_next, hit1_next,
                         above_next, veto4_reg, energy_next, height4_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

// File: rtl/phwc_checker.sv
//==============================================================================
// phwc_checker: port-level checks for the pulse height window classifier
// Watches the input handshake and the result stream; bound to the top level.
//==============================================================================
`default_nettype none

module phwc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [phwc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // A stalled result word stays on the bus unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A vetoed event never reports a threshold or window hit.
    a_veto: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[phwc_pkg::OUT_VETOED_BIT]
        |-> m_tdata[phwc_pkg::OUT_HIT2_BIT:phwc_pkg::OUT_ABOVE_BIT] == 3'b000)
        else $error("vetoed event carries hit flags");

    // The height clamp keeps the most negative code off the bus.
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[phwc_pkg::OUT_HEIGHT_LSB +: phwc_pkg::HEIGHT_W] != 12'h800)
        else $error("pulse height outside clamp range");

    // Input is ready for an offered word whenever no result word is waiting on the output.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready || !s_tvalid || s_tready)
        else $error("input blocked with empty output");

    // Padding bits of the result word are zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[phwc_pkg::OUT_DATA_W-1:phwc_pkg::OUT_PAD_LSB] == 3'b000)
        else $error("result padding not zero");

endmodule

bind pulse_height_window_classifier phwc_checker u_phwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/tb_pulse_height_window_classifier.sv
//==============================================================================
// tb_pulse_height_window_classifier: self-checking bench for the pulse height
// window classifier.
// Streams waveform samples and end-of-event markers into the block, predicts
// every result word from its own model of baseline, peak, veto, calibration
// and window counting, and compares the result stream field by field.
//==============================================================================
module tb_pulse_height_window_classifier;

    import phwc_pkg::*;

    // Number of settings the run steps through. Phase 0 keeps the reset values
    // of every register. Phases 1 and 2 put all registers at opposite extremes.
    // The later phases draw random settings that are centered on energies
    // that the generated events can actually reach.
    localparam int PHASE_COUNT    = 6;
    localparam int BASELINE_PHASE = 3;
    localparam int SHORT_EVENTS   = 5;

    // An idle stretch after the last result leaves ample room for the event
    // state to settle before a register write.
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 500;

    localparam int     INDEX_LIMIT = (1 << INDEX_W) - 1;
    localparam int     HEIGHT_MAX  = 2047;
    localparam longint ENERGY_MAX  = 1048575;
    localparam longint ENERGY_MIN  = -1048576;
    localparam longint KEV_MAX     = (1 << KEV_W) - 1;
    localparam int     SAMPLE_MAX  = 1023;
    localparam int     SAMPLE_MIN  = -1024;

    // One word of the input stream.
    typedef struct packed {
        logic                       marker;
        logic signed [SAMPLE_W-1:0] sample;
    } stream_word_t;

    // One result word. The first member sits in the highest bits, so this
    // struct lines up with m_tdata[100:0].
    typedef struct packed {
        logic [TOTAL_W-1:0]         second_total;
        logic [TOTAL_W-1:0]         first_total;
        logic                       second_hit;
        logic                       first_hit;
        logic                       above;
        logic                       vetoed;
        logic signed [ENERGY_W-1:0] energy;
        logic signed [HEIGHT_W-1:0] height;
    } pulse_result_t;

    //--------------------------------------------------------------------------
    // Clock, reset and the ports of the block
    //--------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;     // [10:0] sample, [15:11] zero
    logic                  s_tuser   = 1'b0;   // [0] action (1 = marker)
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // [11:0] pulse_height,
                                               // [32:12] energy_kev,
                                               // [33] vetoed,
                                               // [34] above_threshold,
                                               // [35] first_window_hit,
                                               // [36] second_window_hit,
                                               // [68:37] first_window_total,
                                               // [100:69] second_window_total,
                                               // [103:101] zero

    pulse_height_window_classifier #(
        .BASELINE_START (BASELINE_START_DEF),
        .BASELINE_LEN   (BASELINE_LEN_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    //--------------------------------------------------------------------------
    // Predictor state: a copy of the registers and of the event state
    //--------------------------------------------------------------------------
    int gain_q88;
    int offset_kev;
    int threshold_kev;
    int first_low_kev;
    int first_high_kev;
    int second_low_kev;
    int second_high_kev;
    int veto_level;

    int                 event_index;
    int                 baseline_sum;
    int                 event_peak;
    bit                 event_vetoed;
    bit                 marker_seen;
    logic [TOTAL_W-1:0] first_hits;
    logic [TOTAL_W-1:0] second_hits;

    stream_word_t  pending_words[$];     // words waiting for the driver
    pulse_result_t expected_results[$];  // predicted results, oldest first
    stream_word_t  word_on_bus;          // the word currently offered
    int            words_left  = 0;      // queued words not yet accepted
    int            mismatches  = 0;
    bit            quiet_tail  = 1'b0;   // no idling on either side when set
    bit            src_bursty  = 1'b1;
    bit            sink_bursty = 1'b1;
    int            src_wait    = 0;
    int            sink_wait   = 0;

    function automatic void clear_event();
        event_index  = 0;
        baseline_sum = 0;
        event_peak   = PEAK_RST;
        event_vetoed = 1'b0;
    endfunction

    // Gain in Q8.8 with a shift that rounds toward minus infinity, then the
    // offset, then saturation to the 21-bit signed result range.
    function automatic longint calibrate(int height);
        longint energy;
        energy = (longint'(gain_q88) * height) >>> 8;
        energy = energy + offset_kev;
        if (energy > ENERGY_MAX)
            energy = ENERGY_MAX;
        if (energy < ENERGY_MIN)
            energy = ENERGY_MIN;
        return energy;
    endfunction

    // Advances the predicted event state by one accepted word. A marker after
    // the first one closes the event and queues the result it must produce.
    function automatic void predict_word(stream_word_t w);
        int            smp;
        int            baseline;
        int            height;
        longint        energy;
        bit            counted;
        pulse_result_t r;
        smp = $signed(w.sample);
        if (!w.marker)
        begin
            // The baseline window excludes both of its end indexes.
            if (event_index > BASELINE_START_DEF &&
                event_index < BASELINE_START_DEF + BASELINE_LEN_DEF)
                baseline_sum += smp;
            if (smp > event_peak)
                event_peak = smp;
            if (smp < veto_level)
                event_vetoed = 1'b1;
            if (event_index < INDEX_LIMIT)
                event_index++;
        end
        else if (!marker_seen)
        begin
            // The first marker only opens the first event.
            marker_seen = 1'b1;
            clear_event();
        end
        else
        begin
            // SystemVerilog division truncates toward zero, as required.
            baseline = baseline_sum / BASELINE_LEN_DEF;
            height   = event_peak - baseline;
            if (height > HEIGHT_MAX)
                height = HEIGHT_MAX;
            if (height < -HEIGHT_MAX)
                height = -HEIGHT_MAX;
            energy  = calibrate(height);
            counted = !event_vetoed;

            r.height     = height[HEIGHT_W-1:0];
            r.energy     = energy[ENERGY_W-1:0];
            r.vetoed     = event_vetoed;
            r.above      = counted && energy > threshold_kev;
            r.first_hit  = counted && energy > first_low_kev && energy < first_high_kev;
            r.second_hit = counted && energy > second_low_kev && energy < second_high_kev;
            // The hit totals stop at their maximum instead of wrapping.
            if (r.first_hit && first_hits != '1)
                first_hits++;
            if (r.second_hit && second_hits != '1)
                second_hits++;
            r.first_total  = first_hits;
            r.second_total = second_hits;
            expected_results.push_back(r);
            clear_event();
        end
    endfunction

    //--------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, and every one is counted.
    //--------------------------------------------------------------------------
    task automatic report_mismatch(string line);
        $display("%0t: %s", $time, line);
        mismatches++;
    endtask

    task automatic compare_field(string field, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    //--------------------------------------------------------------------------
    // Driver: offers queued words on the input stream. It holds a word until
    // it is taken, and after a taken word it may insert an idle burst before
    // the next one. Bursty and steady stretches alternate at random.
    always @(posedge clk)
    begin : word_driver
        stream_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_word(word_on_bus);
                words_left--;
                if (!quiet_tail && src_bursty && $urandom_range(0, 3) == 0)
                    src_wait = $urandom_range(1, 5);
                if ($urandom_range(0, 49) == 0)
                    src_bursty = !src_bursty;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w           = pending_words.pop_front();
                    word_on_bus = w;
                    s_tvalid    <= 1'b1;
                    s_tdata     <= {{(IN_DATA_W - SAMPLE_W){1'b0}}, w.sample};
                    s_tuser     <= w.marker;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Monitor: checks each taken result word against the oldest prediction
    // and stalls the result stream in random bursts.
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        pulse_result_t got;
        pulse_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = pulse_result_t'(m_tdata[OUT_PAD_LSB-1:0]);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word arrived with no result expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("pulse_height", got.height, want.height);
                    compare_field("energy_kev", got.energy, want.energy);
                    compare_field("vetoed", got.vetoed, want.vetoed);
                    compare_field("above_threshold", got.above, want.above);
                    compare_field("first_window_hit", got.first_hit, want.first_hit);
                    compare_field("second_window_hit", got.second_hit, want.second_hit);
                    compare_field("first_window_total", got.first_total, want.first_total);
                    compare_field("second_window_total", got.second_total,
                                  want.second_total);
                    compare_field("padding", m_tdata[OUT_DATA_W-1:OUT_PAD_LSB], 0);
                end
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_tail && sink_bursty && $urandom_range(0, 5) == 0)
                    sink_wait = $urandom_range(1, 5);
            end
            if ($urandom_range(0, 63) == 0)
                sink_bursty = !sink_bursty;
        end
    end

    //--------------------------------------------------------------------------
    // Watchdog: a correct block never goes this long without taking or
    // giving a word, so a run that does is ended as a failure.
    //--------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------------
    function automatic void push_word(bit marker, logic [SAMPLE_W-1:0] sample);
        stream_word_t w;
        w.marker = marker;
        w.sample = sample;
        pending_words.push_back(w);
        words_left++;
    endfunction

    // Queues one event: a flat noisy level with a single peak somewhere in it,
    // closed by a marker. One event in ten is pure noise across the whole
    // sample range. The sample field of the marker is random, since the block
    // must ignore it.
    function automatic void queue_event(int length);
        int level;
        int spread;
        int peak;
        int peak_at;
        int v;
        bit scrambled;
        level     = $urandom_range(0, 1200);
        level     = level - 900;
        spread    = $urandom_range(0, 40);
        peak      = $urandom_range(0, SAMPLE_MAX - level) + level;
        peak_at   = (length > 0) ? $urandom_range(0, length - 1) : 0;
        scrambled = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < length; i++)
        begin
            if (scrambled)
                v = $urandom_range(0, 2047) - 1024;
            else if (i == peak_at)
                v = peak;
            else
                v = level + $urandom_range(0, 2 * spread) - spread;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            if (v < SAMPLE_MIN)
                v = SAMPLE_MIN;
            push_word(1'b0, v[SAMPLE_W-1:0]);
        end
        push_word(1'b1, SAMPLE_W'($urandom));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] kev_clip(longint energy);
        if (energy < 0)
            return '0;
        if (energy > KEV_MAX)
            return KEV_MAX[CFG_DATA_W-1:0];
        return energy[CFG_DATA_W-1:0];
    endfunction

    // Writes one register and mirrors it in the predictor. Writes happen only
    // while no word is in flight, so the mirror may change right away.
    task automatic write_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            CFG_GAIN:               gain_q88        = v[GAIN_W-1:0];
            CFG_OFFSET:             offset_kev      = $signed(v[OFFSET_W-1:0]);
            CFG_THRESHOLD:          threshold_kev   = v[KEV_W-1:0];
            CFG_FIRST_WINDOW_LOW:   first_low_kev   = v[KEV_W-1:0];
            CFG_FIRST_WINDOW_HIGH:  first_high_kev  = v[KEV_W-1:0];
            CFG_SECOND_WINDOW_LOW:  second_low_kev  = v[KEV_W-1:0];
            CFG_SECOND_WINDOW_HIGH: second_high_kev = v[KEV_W-1:0];
            CFG_VETO_LEVEL:         veto_level      = $signed(v[SAMPLE_W-1:0]);
            default:                ;
        endcase
    endtask

    // Picks the settings of one phase. Gain and offset are written first, so
    // that the threshold and the windows can be placed around energies that
    // the events of the phase are likely to produce.
    task automatic choose_setup(int phase);
        int     off;
        int     veto;
        int     pick;
        longint center;
        longint half;
        if (phase == 1)
        begin
            // Everything wide open: both windows span the whole keV range and no sample can cross the veto level.
            write_register(CFG_GAIN, 20'hFFFF);
            write_register(CFG_OFFSET, 20'h07FFF);
            write_register(CFG_THRESHOLD, '0);
            write_register(CFG_FIRST_WINDOW_LOW, '0);
            write_register(CFG_FIRST_WINDOW_HIGH, KEV_MAX[CFG_DATA_W-1:0]);
            write_register(CFG_SECOND_WINDOW_LOW, '0);
            write_register(CFG_SECOND_WINDOW_HIGH, KEV_MAX[CFG_DATA_W-1:0]);
            write_register(CFG_VETO_LEVEL, 20'h00400);
        end
        else if (phase == 2)
        begin
            // Everything shut: zero gain, lowest offset, and a veto level at
            // which any sample below full scale vetoes the event.
            write_register(CFG_GAIN, '0);
            write_register(CFG_OFFSET, 20'h08000);
            write_register(CFG_THRESHOLD, KEV_MAX[CFG_DATA_W-1:0]);
            write_register(CFG_FIRST_WINDOW_LOW, KEV_MAX[CFG_DATA_W-1:0]);
            write_register(CFG_FIRST_WINDOW_HIGH, '0);
            write_register(CFG_SECOND_WINDOW_LOW, KEV_MAX[CFG_DATA_W-1:0]);
            write_register(CFG_SECOND_WINDOW_HIGH, '0);
            write_register(CFG_VETO_LEVEL, 20'h003FF);
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_register(CFG_GAIN, '0);
            else if (pick == 1)
                write_register(CFG_GAIN, 20'hFFFF);
            else
                write_register(CFG_GAIN, CFG_DATA_W'($urandom_range(200, 4000)));

            if ($urandom_range(0, 3) == 0)
                off = $urandom_range(0, 65535);
            else
                off = $urandom_range(0, 2000);
            off = ($urandom_range(0, 3) == 0) ? off - 32768 : off - 1000;
            write_register(CFG_OFFSET, {4'b0, off[OFFSET_W-1:0]});

            if ($urandom_range(0, 7) == 0)
                write_register(CFG_THRESHOLD, '0);
            else
                write_register(CFG_THRESHOLD, kev_clip(calibrate($urandom_range(0, 1500))));

            center = calibrate($urandom_range(0, 1800));
            half   = longint'($urandom_range(1, 800));
            write_register(CFG_FIRST_WINDOW_LOW, kev_clip(center - half));
            write_register(CFG_FIRST_WINDOW_HIGH, kev_clip(center + half));
            center = calibrate($urandom_range(0, 1800));
            half   = longint'($urandom_range(1, 800));
            write_register(CFG_SECOND_WINDOW_LOW, kev_clip(center - half));
            write_register(CFG_SECOND_WINDOW_HIGH, kev_clip(center + half));

            // Mostly a low veto level that only deep dips cross; now and then
            // one anywhere in the sample range.
            veto = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                               : $urandom_range(0, 400);
            veto = veto - 1024;
            write_register(CFG_VETO_LEVEL, {9'b0, veto[SAMPLE_W-1:0]});
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every phase has a run of short events and empty ones. One phase also
    // carries an event whose length lands near either edge of the baseline
    // window, so that it may or may not reach into it.
    function automatic void queue_phase(int phase);
        int length;
        if (phase == BASELINE_PHASE)
            queue_event($urandom_range(398, 460));
        for (int n = 0; n < SHORT_EVENTS; n++)
        begin
            length = ($urandom_range(0, 99) < 12) ? 0 : $urandom_range(1, 20);
            queue_event(length);
        end
    endfunction

    task automatic wait_until_drained();
        while (words_left > 0 || expected_results.size() > 0)
            @(posedge clk);
    endtask

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial
    begin : stimulus
        gain_q88        = GAIN_RST;
        offset_kev      = OFFSET_RST;
        threshold_kev   = THRESHOLD_RST;
        first_low_kev   = FW_LOW_RST;
        first_high_kev  = FW_HIGH_RST;
        second_low_kev  = SW_LOW_RST;
        second_high_kev = SW_HIGH_RST;
        veto_level      = VETO_RST;
        marker_seen     = 1'b0;
        first_hits      = '0;
        second_hits     = '0;
        clear_event();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under reset settings. Samples ahead of the first
        // marker must leave no trace.
        push_word(1'b0, 11'sd1023);
        push_word(1'b0, -11'sd1024);
        push_word(1'b1, 11'sd0);
        // An empty event: the peak is still at its reset value.
        push_word(1'b1, 11'sd1023);
        // Both extremes and alternating bit patterns in one event.
        push_word(1'b0, -11'sd1024);
        push_word(1'b0, 11'sd1023);
        push_word(1'b0, 11'sd682);
        push_word(1'b0, -11'sd683);
        push_word(1'b0, 11'sd0);
        push_word(1'b0, -11'sd1);
        push_word(1'b1, -11'sd1);
        // Zero height, and a height of minus one whose energy must round
        // down rather than toward zero.
        push_word(1'b0, 11'sd0);
        push_word(1'b1, 11'sd0);
        push_word(1'b0, -11'sd1);
        push_word(1'b1, 11'sd0);
        // Heights around the default threshold of 2000 keV.
        push_word(1'b0, 11'sd416);
        push_word(1'b1, 11'sd0);
        push_word(1'b0, 11'sd417);
        push_word(1'b1, 11'sd0);
        push_word(1'b0, 11'sd1023);
        push_word(1'b1, 11'sd0);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                // The sender holds off until every result is back, and then a
                // little longer, before the settings change.
                wait_until_drained();
                repeat (DRAIN_CYCLES) @(posedge clk);
                choose_setup(phase);
            end
            if (phase == PHASE_COUNT - 1)
                quiet_tail = 1'b1;
            queue_phase(phase);
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
